// File: rtl/gbfs_pkg.sv
// Shared types and constants for the grid breadth-first path finder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package gbfs_pkg;
	localparam int MAX_ROWS = 8;
	localparam int MAX_COLS = 8;
	localparam int NCELLS   = MAX_ROWS * MAX_COLS;
	localparam int CELL_W   = 6;
	localparam int CNT_W    = 7;

	localparam logic [1:0] KIND_OPEN = 2'd0;
	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_EXIT = 2'd2;

	localparam logic [1:0] ST_PATH    = 2'd0;
	localparam logic [1:0] ST_BLOCKED = 2'd1;
	localparam logic [1:0] ST_NO_PATH = 2'd2;
	localparam logic [1:0] ST_AT_EXIT = 2'd3;

	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [2:0] row;
		logic [2:0] col;
		logic [1:0] cell_kind;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] row_res;
		logic [2:0] col_res;
		logic       last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic       load_grid;
		logic       start_solve;
		logic       init_search;
		logic       pop_queue;
		logic       take_node;
		logic       nb_read;
		logic       nb_visit;
		logic       dir_clr;
		logic       dir_inc;
		logic       bt_init;
		logic       bt_push;
		logic       bt_step;
		logic       pop_stack;
		logic       emit;
		logic [1:0] emit_status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_solve;
		logic start_bad;
		logic start_exit;
		logic queue_empty;
		logic node_exit;
		logic nb_valid;
		logic dir_last;
		logic at_is_start;
		logic depth_zero;
		logic out_free;
	} dp_sts_t;
endpackage

// File: rtl/gbfs_dp.sv
// Datapath: grid, visited map, predecessor, queue and path stack storage,
// neighbor generation, region registers and the output register. Uses gbfs_pkg.
`timescale 1ns / 1ps
module gbfs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  gbfs_pkg::in_item_t  in_data,
	input  logic                cfg_wr,
	input  logic                cfg_index,
	input  logic [3:0]          cfg_data,
	input  gbfs_pkg::dp_cmd_t   cmd,
	output gbfs_pkg::dp_sts_t   sts,
	output logic                out_valid,
	input  logic                out_stall,
	output gbfs_pkg::out_item_t out_data
);
	import gbfs_pkg::*;

	logic [1:0]        grid_mem [NCELLS];
	logic [1:0]        cf_mem [NCELLS];
	logic [CELL_W-1:0] queue_mem [NCELLS];
	logic [CELL_W-1:0] stack_mem [NCELLS];

	logic [3:0]        rows_q, cols_q;
	logic [3:0]        rows_eff, cols_eff;
	logic [NCELLS-1:0] visited_q;
	logic [NCELLS-1:0] grid_set_q;
	logic [1:0]        grid_raw_q;
	logic              grid_hit_q;
	logic [1:0]        grid_rd;
	logic              grid_wr;
	logic [1:0]        cf_rd_q;
	logic [CELL_W-1:0] q_rd_q, sd_q;
	logic [CELL_W-1:0] start_q, node_q, t_q, at_q;
	logic              bad_q;
	logic [CNT_W-1:0]  head_q, tail_q, depth_q;
	logic [1:0]        dir_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [CELL_W-1:0] in_cell, nb_cell, grid_raddr, at_next;
	logic [2:0]        nr, nc, tr, tc, ar, ac;
	logic              nb_ok, grid_rd_en;
	logic [CNT_W-1:0]  depth_dec;

	// clamp region registers to 1..MAX
	always_comb begin
		rows_eff = (rows_q == 4'd0) ? 4'd1 : (rows_q > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_q;
		cols_eff = (cols_q == 4'd0) ? 4'd1 : (cols_q > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cols_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd5;
			cols_q <= 4'd7;
		end else if (cfg_wr) begin
			if (cfg_index == REG_ROWS) rows_q <= cfg_data;
			else rows_q <= rows_q;
			if (cfg_index == REG_COLS) cols_q <= cfg_data;
			else cols_q <= cols_q;
		end
	end

	assign in_cell = {in_data.row, in_data.col};

	// neighbor of the current node in the current direction
	assign nr = node_q[5:3];
	assign nc = node_q[2:0];
	always_comb begin
		tr    = nr;
		tc    = nc;
		nb_ok = 1'b0;
		case (dir_q)
			DIR_DOWN: begin
				nb_ok = ({1'b0, nr} + 4'd1) < rows_eff;
				tr    = nr + 3'd1;
			end
			DIR_UP: begin
				nb_ok = (nr != 3'd0);
				tr    = nr - 3'd1;
			end
			DIR_RIGHT: begin
				nb_ok = ({1'b0, nc} + 4'd1) < cols_eff;
				tc    = nc + 3'd1;
			end
			default: begin
				nb_ok = (nc != 3'd0);
				tc    = nc - 3'd1;
			end
		endcase
	end
	assign nb_cell = {tr, tc};

	// step back toward the start along the stored direction
	always_comb begin
		ar = at_q[5:3];
		ac = at_q[2:0];
		case (cf_rd_q)
			DIR_DOWN:  ar = at_q[5:3] - 3'd1;
			DIR_UP:    ar = at_q[5:3] + 3'd1;
			DIR_RIGHT: ac = at_q[2:0] - 3'd1;
			default:   ac = at_q[2:0] + 3'd1;
		endcase
	end
	assign at_next = {ar, ac};

	// grid read address select
	always_comb begin
		grid_rd_en = cmd.start_solve | cmd.take_node | cmd.nb_read;
		if (cmd.start_solve) grid_raddr = in_cell;
		else if (cmd.take_node) grid_raddr = q_rd_q;
		else grid_raddr = nb_cell;
	end

	assign grid_wr = cmd.load_grid && (in_data.cell_kind <= KIND_EXIT);

	// grid memory
	always_ff @(posedge clk) begin
		if (grid_wr) grid_mem[in_cell] <= in_data.cell_kind;
		if (grid_rd_en) grid_raw_q <= grid_mem[grid_raddr];
	end

	// mark loaded cells; a cell never loaded reads as open
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_set_q <= '0;
			grid_hit_q <= 1'b0;
		end else begin
			if (grid_wr) grid_set_q[in_cell] <= 1'b1;
			if (grid_rd_en) grid_hit_q <= grid_set_q[grid_raddr];
		end
	end
	assign grid_rd = grid_hit_q ? grid_raw_q : KIND_OPEN;

	// queue memory
	always_ff @(posedge clk) begin
		if (cmd.init_search) queue_mem[6'd0] <= start_q;
		else if (cmd.nb_visit && grid_rd != KIND_WALL && !visited_q[t_q]
			&& tail_q < CNT_W'(NCELLS))
			queue_mem[tail_q[CELL_W-1:0]] <= t_q;
		if (cmd.pop_queue) q_rd_q <= queue_mem[head_q[CELL_W-1:0]];
	end

	// predecessor memory
	always_ff @(posedge clk) begin
		if (cmd.nb_visit && grid_rd != KIND_WALL && !visited_q[t_q]) cf_mem[t_q] <= dir_q;
		if (cmd.bt_push) cf_rd_q <= cf_mem[at_q];
	end

	// path stack memory
	assign depth_dec = depth_q - CNT_W'(1);
	always_ff @(posedge clk) begin
		if (cmd.bt_push) stack_mem[depth_q[CELL_W-1:0]] <= at_q;
		if (cmd.pop_stack) sd_q <= stack_mem[depth_dec[CELL_W-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start_solve) begin
			start_q <= in_cell;
			bad_q   <= ({1'b0, in_data.row} >= rows_eff) || ({1'b0, in_data.col} >= cols_eff);
		end
		if (cmd.take_node) node_q <= q_rd_q;
		if (cmd.nb_read) t_q <= nb_cell;
		if (cmd.bt_init) at_q <= node_q;
		else if (cmd.bt_step) at_q <= at_next;
	end

	// search control counters and visited map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			depth_q   <= '0;
			dir_q     <= DIR_DOWN;
		end else begin
			if (cmd.init_search) begin
				visited_q <= NCELLS'(1) << start_q;
				head_q    <= '0;
				tail_q    <= CNT_W'(1);
			end else begin
				if (cmd.pop_queue) head_q <= head_q + CNT_W'(1);
				if (cmd.nb_visit && grid_rd != KIND_WALL && !visited_q[t_q]) begin
					visited_q[t_q] <= 1'b1;
					if (tail_q < CNT_W'(NCELLS)) tail_q <= tail_q + CNT_W'(1);
				end
			end
			if (cmd.dir_clr) dir_q <= DIR_DOWN;
			else if (cmd.dir_inc) dir_q <= dir_q + 2'd1;
			if (cmd.bt_init) depth_q <= '0;
			else if (cmd.bt_push) depth_q <= depth_q + CNT_W'(1);
			else if (cmd.pop_stack) depth_q <= depth_dec;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status <= cmd.emit_status;
			if (cmd.emit_status == ST_PATH) begin
				out_q.row_res <= sd_q[5:3];
				out_q.col_res <= sd_q[2:0];
				out_q.last    <= (depth_q == '0);
			end else begin
				out_q.row_res <= 3'd0;
				out_q.col_res <= 3'd0;
				out_q.last    <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status toward the controller
	always_comb begin
		sts.in_solve    = (in_data.cmd == CMD_SOLVE);
		sts.start_bad   = bad_q || (grid_rd == KIND_WALL);
		sts.start_exit  = (grid_rd == KIND_EXIT);
		sts.queue_empty = (head_q == tail_q);
		sts.node_exit   = (grid_rd == KIND_EXIT);
		sts.nb_valid    = nb_ok;
		sts.dir_last    = (dir_q == DIR_LEFT);
		sts.at_is_start = (at_q == start_q);
		sts.depth_zero  = (depth_q == '0);
		sts.out_free    = !out_valid_q || !out_stall;
	end
endmodule

// File: rtl/gbfs_ctrl.sv
// Controller state machine: sequences loads, the search, the backtrace and
// the path output. Uses gbfs_pkg; drives the datapath command struct.
`timescale 1ns / 1ps
module gbfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gbfs_pkg::dp_sts_t sts,
	output gbfs_pkg::dp_cmd_t cmd
);
	import gbfs_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_NODE  = 4'd3;
	localparam logic [3:0] S_NODEG = 4'd4;
	localparam logic [3:0] S_NB    = 4'd5;
	localparam logic [3:0] S_NBG   = 4'd6;
	localparam logic [3:0] S_BT    = 4'd7;
	localparam logic [3:0] S_BTW   = 4'd8;
	localparam logic [3:0] S_POPS  = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;

	logic [3:0] state_q, state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sts.in_solve) begin
						cmd.start_solve = 1'b1;
						state_d         = S_CHK;
					end else begin
						cmd.load_grid = 1'b1;
					end
				end
			end
			S_CHK: begin
				if (sts.start_bad || sts.start_exit) begin
					if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = sts.start_bad ? ST_BLOCKED : ST_AT_EXIT;
						state_d         = S_IDLE;
					end
				end else begin
					cmd.init_search = 1'b1;
					state_d         = S_POP;
				end
			end
			S_POP: begin
				if (sts.queue_empty) begin
					if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = ST_NO_PATH;
						state_d         = S_IDLE;
					end
				end else begin
					cmd.pop_queue = 1'b1;
					state_d       = S_NODE;
				end
			end
			S_NODE: begin
				cmd.take_node = 1'b1;
				state_d       = S_NODEG;
			end
			S_NODEG: begin
				if (sts.node_exit) begin
					cmd.bt_init = 1'b1;
					state_d     = S_BT;
				end else begin
					cmd.dir_clr = 1'b1;
					state_d     = S_NB;
				end
			end
			S_NB: begin
				if (sts.nb_valid) begin
					cmd.nb_read = 1'b1;
					state_d     = S_NBG;
				end else if (sts.dir_last) begin
					state_d = S_POP;
				end else begin
					cmd.dir_inc = 1'b1;
				end
			end
			S_NBG: begin
				cmd.nb_visit = 1'b1;
				if (sts.dir_last) begin
					state_d = S_POP;
				end else begin
					cmd.dir_inc = 1'b1;
					state_d     = S_NB;
				end
			end
			S_BT: begin
				if (sts.at_is_start) begin
					state_d = S_POPS;
				end else begin
					cmd.bt_push = 1'b1;
					state_d     = S_BTW;
				end
			end
			S_BTW: begin
				cmd.bt_step = 1'b1;
				state_d     = S_BT;
			end
			S_POPS: begin
				cmd.pop_stack = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_PATH;
					state_d         = sts.depth_zero ? S_IDLE : S_POPS;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// File: rtl/grid_bfs_shortest_path.sv
// Grid shortest path by breadth-first search. A solve accepts and checks the start,
// then searches dequeued cells (one grid memory read per neighbor), backtraces the
// path and emits its cells in forward order; the single grid read port sets the pace.
// One item is in work at a time. Reset clears control state, the visited map and
// the loaded-cell flags, so the grid reads all open; region is 5 rows, 7 columns.
`timescale 1ns / 1ps
module grid_bfs_shortest_path (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gbfs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gbfs_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [3:0]          cfg_data
);
	import gbfs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// configuration always taken
	assign cfg_ready = 1'b1;

	gbfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);
endmodule

// File: tb/grid_bfs_shortest_path_tb.sv
// Self-checking testbench for the grid breadth-first path finder.
// Depends on gbfs_pkg and grid_bfs_shortest_path; predicts every path result in-bench.
`timescale 1ns / 1ps
module grid_bfs_shortest_path_tb;
	import gbfs_pkg::*;

	typedef struct packed {
		logic       has_exp;
		in_item_t   item;
		out_item_t  exp;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = REG_ROWS;
	logic [3:0] cfg_data = '0;

	// predictor state
	logic [1:0] grid_mdl [NCELLS];
	logic [3:0] rows_reg, cols_reg;
	out_item_t  path_exp_q [$];
	int         mismatches = 0;
	int         last_added = 0;
	bit         in_valid_hi = 1'b0;
	bit         quiet_out = 1'b0;
	bit         quiet_in = 1'b0;

	grid_bfs_shortest_path u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int region_size(logic [3:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic out_item_t mk_res(logic [1:0] st, int r, int c, bit lst);
		out_item_t o;
		o.status = st;
		o.row_res = r[2:0];
		o.col_res = c[2:0];
		o.last = lst;
		return o;
	endfunction

	// Apply one item to the grid model and queue the results it causes
	task automatic predict_item(in_item_t it);
		int rows, cols, start, node, head, tail, at, nr, nc, tr, tc, t, d, depth;
		int fq [NCELLS];
		int stk [NCELLS];
		bit seen [NCELLS];
		logic [1:0] from [NCELLS];
		bit found;
		if (it.cmd == CMD_LOAD) begin
			if (it.cell_kind <= KIND_EXIT)
				grid_mdl[it.row * MAX_COLS + it.col] = it.cell_kind;
			return;
		end
		rows = region_size(rows_reg, MAX_ROWS);
		cols = region_size(cols_reg, MAX_COLS);
		start = it.row * MAX_COLS + it.col;
		if (it.row >= rows || it.col >= cols || grid_mdl[start] == KIND_WALL) begin
			path_exp_q.push_back(mk_res(ST_BLOCKED, 0, 0, 1'b1));
			return;
		end
		if (grid_mdl[start] == KIND_EXIT) begin
			path_exp_q.push_back(mk_res(ST_AT_EXIT, 0, 0, 1'b1));
			return;
		end
		foreach (seen[i]) seen[i] = 1'b0;
		head = 0; tail = 1; fq[0] = start; seen[start] = 1'b1;
		found = 1'b0; node = start;
		while (head < tail) begin
			node = fq[head]; head++;
			if (grid_mdl[node] == KIND_EXIT) begin
				found = 1'b1;
				break;
			end
			nr = node / MAX_COLS; nc = node % MAX_COLS;
			for (d = 0; d < 4; d++) begin
				tr = nr; tc = nc;
				case (d[1:0])
					DIR_DOWN: begin if (nr + 1 >= rows) continue; tr = nr + 1; end
					DIR_UP: begin if (nr == 0) continue; tr = nr - 1; end
					DIR_RIGHT: begin if (nc + 1 >= cols) continue; tc = nc + 1; end
					default: begin if (nc == 0) continue; tc = nc - 1; end
				endcase
				t = tr * MAX_COLS + tc;
				if (grid_mdl[t] == KIND_WALL || seen[t]) continue;
				seen[t] = 1'b1;
				from[t] = d[1:0];
				if (tail < NCELLS) begin fq[tail] = t; tail++; end
			end
		end
		if (!found) begin
			path_exp_q.push_back(mk_res(ST_NO_PATH, 0, 0, 1'b1));
			return;
		end
		// walk back to the start, then emit in forward order
		depth = 0; at = node;
		while (at != start && depth < NCELLS) begin
			nr = at / MAX_COLS; nc = at % MAX_COLS;
			stk[depth] = at; depth++;
			case (from[at])
				DIR_DOWN: nr--;
				DIR_UP: nr++;
				DIR_RIGHT: nc--;
				default: nc++;
			endcase
			at = nr * MAX_COLS + nc;
		end
		while (depth > 0) begin
			depth--;
			path_exp_q.push_back(mk_res(ST_PATH, stk[depth] / MAX_COLS,
				stk[depth] % MAX_COLS, depth == 0));
		end
	endtask

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (path_exp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				if (out_data !== path_exp_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", path_exp_q[0], out_data);
				end
				void'(path_exp_q.pop_front());
			end
		end
	end

	// Random receiver stall
	always @(posedge clk) begin
		out_stall <= quiet_out ? 1'b0 : ($urandom_range(0, 99) < 11);
	end

	// Drop input valid once per idle stretch
	task automatic idle_in();
		if (in_valid_hi) begin
			in_valid <= 1'b0;
			in_valid_hi = 1'b0;
		end
	endtask

	task automatic send_item(in_item_t it);
		while (!quiet_in && $urandom_range(0, 99) < 11) begin
			idle_in();
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_valid_hi = 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		last_added = path_exp_q.size();
		predict_item(it);
		last_added = path_exp_q.size() - last_added;
	endtask

	task automatic drain_all();
		idle_in();
		while (path_exp_q.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS) rows_reg = val;
		else cols_reg = val;
		@(posedge clk);
	endtask

	function automatic in_item_t mk_in(logic cmd, int r, int c, int k);
		in_item_t it;
		it.cmd = cmd; it.row = r[2:0]; it.col = c[2:0]; it.cell_kind = k[1:0];
		return it;
	endfunction

	function automatic in_item_t rand_load();
		return mk_in(CMD_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
			($urandom_range(0, 9) < 3) ? KIND_WALL : KIND_OPEN);
	endfunction

	initial begin
		stim_row_t dir_tbl [$];
		stim_row_t sr;
		int r, c;
		for (int i = 0; i < NCELLS; i++) grid_mdl[i] = KIND_OPEN;
		rows_reg = 4'd5; cols_reg = 4'd7;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: known answers where obvious, predictor elsewhere
		dir_tbl.push_back('{1'b1, mk_in(CMD_SOLVE, 0, 0, 0), mk_res(ST_NO_PATH, 0, 0, 1)});
		dir_tbl.push_back('{1'b1, mk_in(CMD_SOLVE, 7, 7, 3), mk_res(ST_BLOCKED, 0, 0, 1)});
		dir_tbl.push_back('{1'b1, mk_in(CMD_SOLVE, 0, 7, 0), mk_res(ST_BLOCKED, 0, 0, 1)});
		dir_tbl.push_back('{1'b0, mk_in(CMD_LOAD, 4, 6, KIND_EXIT), '0});
		dir_tbl.push_back('{1'b1, mk_in(CMD_SOLVE, 4, 6, 0), mk_res(ST_AT_EXIT, 0, 0, 1)});
		dir_tbl.push_back('{1'b0, mk_in(CMD_SOLVE, 0, 0, 0), '0});
		dir_tbl.push_back('{1'b0, mk_in(CMD_LOAD, 2, 2, KIND_WALL), '0});
		dir_tbl.push_back('{1'b1, mk_in(CMD_SOLVE, 2, 2, 0), mk_res(ST_BLOCKED, 0, 0, 1)});
		dir_tbl.push_back('{1'b0, mk_in(CMD_LOAD, 2, 2, 3), '0});
		dir_tbl.push_back('{1'b0, mk_in(CMD_LOAD, 7, 7, KIND_EXIT), '0});
		dir_tbl.push_back('{1'b0, mk_in(CMD_LOAD, 0, 0, KIND_EXIT), '0});
		dir_tbl.push_back('{1'b0, mk_in(CMD_SOLVE, 3, 3, 0), '0});
		dir_tbl.push_back('{1'b0, mk_in(CMD_LOAD, 0, 0, KIND_OPEN), '0});
		dir_tbl.push_back('{1'b0, mk_in(CMD_LOAD, 4, 6, KIND_OPEN), '0});
		dir_tbl.push_back('{1'b0, mk_in(CMD_SOLVE, 1, 1, 0), '0});
		foreach (dir_tbl[i]) begin
			sr = dir_tbl[i];
			send_item(sr.item);
			if (sr.has_exp && (last_added != 1 || path_exp_q[$] !== sr.exp)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: expected %h model %h", i, sr.exp,
						(last_added > 0) ? path_exp_q[$] : out_item_t'(0));
			end
		end
		drain_all();

		// full 8x8 region: solve, then wall off the exit and solve again; then a 1x1 region
		write_reg(REG_ROWS, 4'd15);
		write_reg(REG_COLS, 4'd8);
		send_item(mk_in(CMD_SOLVE, 0, 0, 0));
		send_item(mk_in(CMD_LOAD, 7, 6, KIND_WALL));
		send_item(mk_in(CMD_LOAD, 6, 7, KIND_WALL));
		send_item(mk_in(CMD_SOLVE, 0, 0, 0));
		drain_all();
		write_reg(REG_ROWS, 4'd0);
		write_reg(REG_COLS, 4'd0);
		send_item(mk_in(CMD_SOLVE, 0, 0, 0));
		send_item(mk_in(CMD_SOLVE, 0, 1, 0));
		drain_all();

		// random phases: grid edits followed by a solve, varied region
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_ROWS, $urandom_range(0, 15));
			write_reg(REG_COLS, $urandom_range(0, 15));
			quiet_out = (ph == 2);
			quiet_in = (ph == 2);
			for (int k = 0; k < 8; k++) begin
				repeat ($urandom_range(1, 5)) send_item(rand_load());
				send_item(mk_in(CMD_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : KIND_EXIT));
				r = $urandom_range(0, 7); c = $urandom_range(0, 7);
				send_item(mk_in(CMD_SOLVE, r, c, $urandom_range(0, 3)));
				if (k == 4) begin
					idle_in();
					@(posedge clk);
					while (path_exp_q.size() != 0) @(posedge clk);
				end
			end
			drain_all();
		end
		quiet_out = 1'b0;
		quiet_in = 1'b0;
		if (mismatches == 0 && path_exp_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end
endmodule
